// ===== sv/pal_pkg.sv =====
`default_nettype none

package pal_pkg;

  localparam int unsigned DEPTH_DEF  = 64;
  localparam int unsigned ELEM_W_DEF = 32;

  localparam int unsigned ACT_W   = 3;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 6;

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND = 3'd0,
    ACT_INSERT = 3'd1,
    ACT_READ   = 3'd2,
    ACT_DELETE = 3'd3,
    ACT_CLEAR  = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_UP,
    S_UP_END,
    S_UP_PUT,
    S_DN,
    S_DN_END,
    S_FIN
  } state_e;

endpackage

`default_nettype wire

// ===== sv/positional_array_list.sv =====
// Append, clear and errors go straight to the finish state; read goes through S_RD;
// insert at p into length n shifts elements n-1 down to p up; delete at p shifts p+1..n-1 down.
// One item at a time: the next beat is taken once the previous one finishes.
// Each shifted element passes through the store's single read port.
// Reset: length zero, no result pending; store contents are not cleared.
`default_nettype none

module positional_array_list #(
  parameter int unsigned DEPTH      = pal_pkg::DEPTH_DEF,
  parameter int unsigned ELEM_WIDTH = pal_pkg::ELEM_W_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [pal_pkg::ACT_W-1:0]     action_i,
  input  wire logic [pal_pkg::POS_W-1:0]     position_i,
  input  wire logic signed [pal_pkg::DATA_W-1:0] value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               status_o,
  output logic signed [pal_pkg::DATA_W-1:0]  read_value_o,
  output logic [pal_pkg::COUNT_W-1:0]        count_o,
  output logic                               is_empty_o,
  output logic                               is_full_o
);

  import pal_pkg::*;

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CMP_W = (AW > POS_W) ? AW : POS_W;
  localparam logic [AW-1:0] FULL_LEN = AW'(DEPTH - 1);

  state_e state_q, state_d;
  logic [AW-1:0] len_q, len_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [AW-1:0] wptr_q, wptr_d;
  logic pend_q, pend_d;
  logic first_q, first_d;
  logic status_q, status_d;
  logic [ELEM_WIDTH-1:0] val_q, val_d;
  logic [ELEM_WIDTH-1:0] res_q, res_d;

  logic out_valid_q;
  logic out_status_q;
  logic [ELEM_WIDTH-1:0] out_res_q;
  logic [AW-1:0] out_len_q;

  logic mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [ELEM_WIDTH-1:0] mem_wdata, mem_rdata;

  logic in_fire, out_free, out_load;
  logic [CMP_W-1:0] pos_cmp, len_cmp;
  logic [AW-1:0] pos_addr;
  logic [ELEM_WIDTH-1:0] val_in;

  assign pos_cmp  = CMP_W'(position_i);
  assign len_cmp  = CMP_W'(len_q);
  assign pos_addr = pos_cmp[AW-1:0];

  generate
    if (ELEM_WIDTH <= DATA_W) begin : g_val_narrow
      assign val_in       = value_i[ELEM_WIDTH-1:0];
    end else begin : g_val_wide
      assign val_in       = {{(ELEM_WIDTH - DATA_W){value_i[DATA_W-1]}}, value_i};
    end
    if (ELEM_WIDTH >= DATA_W) begin : g_rv_narrow
      assign read_value_o = out_res_q[DATA_W-1:0];
    end else begin : g_rv_wide
      assign read_value_o = {{(DATA_W - ELEM_WIDTH){out_res_q[ELEM_WIDTH-1]}}, out_res_q};
    end
    if (AW >= COUNT_W) begin : g_cnt_trunc
      assign count_o = out_len_q[COUNT_W-1:0];
    end else begin : g_cnt_ext
      assign count_o = {{(COUNT_W - AW){1'b0}}, out_len_q};
    end
  endgenerate

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_load    = (state_q == S_FIN) && out_free;
  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign is_empty_o  = (out_len_q == '0);
  assign is_full_o   = (out_len_q == FULL_LEN);

  pal_store #(
    .DEPTH      (DEPTH),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d   = state_q;
    len_d     = len_q;
    pos_d     = pos_q;
    ptr_d     = ptr_q;
    wptr_d    = wptr_q;
    pend_d    = pend_q;
    first_d   = first_q;
    status_d  = status_q;
    val_d     = val_q;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_waddr = wptr_q;
    mem_wdata = mem_rdata;
    mem_raddr = ptr_q;

    case (state_q)
      S_IDLE: begin
        mem_raddr = pos_addr;
        if (in_fire) begin
          status_d = 1'b0;
          res_d    = '0;
          pos_d    = pos_addr;
          val_d    = val_in;
          pend_d   = 1'b0;
          first_d  = 1'b1;
          state_d  = S_FIN;
          case (action_e'(action_i))
            ACT_APPEND: begin
              if (len_q >= FULL_LEN) begin
                status_d = 1'b1;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = len_q;
                mem_wdata = val_in;
                len_d     = len_q + AW'(1);
              end
            end
            ACT_INSERT: begin
              if (len_q >= FULL_LEN || pos_cmp > len_cmp) begin
                status_d = 1'b1;
              end else if (pos_cmp == len_cmp) begin
                mem_we    = 1'b1;
                mem_waddr = len_q;
                mem_wdata = val_in;
                len_d     = len_q + AW'(1);
              end else begin
                ptr_d   = len_q - AW'(1);
                state_d = S_UP;
              end
            end
            ACT_READ: begin
              if (pos_cmp >= len_cmp) begin
                status_d = 1'b1;
              end else begin
                state_d = S_RD;
              end
            end
            ACT_DELETE: begin
              if (pos_cmp >= len_cmp) begin
                status_d = 1'b1;
              end else begin
                ptr_d   = pos_addr;
                state_d = S_DN;
              end
            end
            ACT_CLEAR: begin
              len_d = '0;
            end
            default: begin
              status_d = 1'b1;
            end
          endcase
        end
      end
      S_RD: begin
        res_d   = mem_rdata;
        state_d = S_FIN;
      end
      S_UP: begin
        mem_we = pend_q;
        pend_d = 1'b1;
        wptr_d = ptr_q + AW'(1);
        if (ptr_q == pos_q) begin
          state_d = S_UP_END;
        end else begin
          ptr_d = ptr_q - AW'(1);
        end
      end
      S_UP_END: begin
        mem_we  = 1'b1;
        state_d = S_UP_PUT;
      end
      S_UP_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q;
        mem_wdata = val_q;
        len_d     = len_q + AW'(1);
        state_d   = S_FIN;
      end
      S_DN: begin
        if (pend_q) begin
          if (first_q) begin
            res_d   = mem_rdata;
            first_d = 1'b0;
          end else begin
            mem_we = 1'b1;
          end
        end
        pend_d = 1'b1;
        wptr_d = ptr_q - AW'(1);
        if (ptr_q == len_q - AW'(1)) begin
          state_d = S_DN_END;
        end else begin
          ptr_d = ptr_q + AW'(1);
        end
      end
      S_DN_END: begin
        if (first_q) begin
          res_d = mem_rdata;
        end else begin
          mem_we = 1'b1;
        end
        len_d   = len_q - AW'(1);
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      pend_q      <= 1'b0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      pend_q  <= pend_d;
      first_q <= first_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    ptr_q    <= ptr_d;
    wptr_q   <= wptr_d;
    status_q <= status_d;
    val_q    <= val_d;
    res_q    <= res_d;
    if (out_load) begin
      out_status_q <= status_q;
      out_res_q    <= res_q;
      out_len_q    <= len_q;
    end
  end

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= FULL_LEN)
    else $error("list length above full mark");

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_FIN)
    else $error("result beat raised outside finish state");

  a_up_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UP && pend_q) |-> wptr_q != ptr_q)
    else $error("shift-up write collides with read address");

  a_stall_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> in_stall_o)
    else $error("new beat allowed right after accept");

endmodule

`default_nettype wire

// ===== sv/pal_store.sv =====
`default_nettype none

module pal_store #(
  parameter int unsigned DEPTH      = pal_pkg::DEPTH_DEF,
  parameter int unsigned ELEM_WIDTH = pal_pkg::ELEM_W_DEF,
  localparam int unsigned AW        = $clog2(DEPTH)
) (
  input  wire logic                  clk_i,
  input  wire logic                  we_i,
  input  wire logic [AW-1:0]         waddr_i,
  input  wire logic [ELEM_WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]         raddr_i,
  output logic      [ELEM_WIDTH-1:0] rdata_o
);

  logic [ELEM_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire
